@@ rtl/cbq_pkg.sv @@
// ----------------------------------------------------------------------------
// cbq_pkg
// Shared types, sizes and codes for the cascaded biquad filter bank.
// ----------------------------------------------------------------------------
package cbq_pkg;

	localparam int SECTIONS    = 8;
	localparam int SAMPLE_BITS = 24;
	localparam int COEF_BITS   = 32;
	localparam int COEF_FRAC   = COEF_BITS - 8;
	localparam int NCOEF       = 5;
	localparam int ACC_W       = 64;
	localparam int PROD_W      = COEF_BITS + SAMPLE_BITS;

	localparam int CDEPTH    = SECTIONS * NCOEF;
	localparam int CADDR_W   = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
	localparam int SEC_IDX_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
	localparam int SEC_CNT_W = $clog2(SECTIONS + 1);
	localparam int K_W       = $clog2(NCOEF + 2);

	localparam int CFG_N_W  = 4;
	localparam int CFG_EN_W = 8;

	// register word indexes
	localparam logic REG_SECTIONS = 1'b0;
	localparam logic REG_ENABLE   = 1'b1;

	// coefficient order within a section
	localparam int C_B0 = 0;
	localparam int C_B1 = 1;
	localparam int C_B2 = 2;
	localparam int C_A1 = 3;
	localparam int C_A2 = 4;

	typedef enum logic [1:0] {
		OP_FILTER = 2'd0,
		OP_WRITE  = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEC,
		ST_RUN,
		ST_WB,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]                    opcode;
		logic signed [SAMPLE_BITS-1:0] sample_in;
		logic [2:0]                    section;
		logic [2:0]                    coefficient_select;
		logic signed [COEF_BITS-1:0]   coefficient_value;
	} req_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_out;
		logic                          saturated;
	} rsp_t;

	typedef struct packed {
		logic [CFG_N_W-1:0]  sections_in_use;
		logic [CFG_EN_W-1:0] section_enable;
	} cfg_t;

	// one history row: both input and output taps of a section
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] x1;
		logic signed [SAMPLE_BITS-1:0] x2;
		logic signed [SAMPLE_BITS-1:0] y1;
		logic signed [SAMPLE_BITS-1:0] y2;
	} hist_row_t;

	typedef struct packed {
		logic vld;
		logic first;
		logic sub;
	} mac_ctl_t;

endpackage

@@ rtl/cbq_mac.sv @@
// ----------------------------------------------------------------------------
// cbq_mac
// Shared multiply-accumulate with rounding and saturation of the sum.
// ----------------------------------------------------------------------------
module cbq_mac (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  cbq_pkg::mac_ctl_t                      ctl,
	input  logic signed [cbq_pkg::COEF_BITS-1:0]   coef,
	input  logic signed [cbq_pkg::SAMPLE_BITS-1:0] operand,
	output logic signed [cbq_pkg::SAMPLE_BITS-1:0] y,
	output logic                                   clip
);

	localparam logic signed [cbq_pkg::ACC_W-1:0] SMAX =
		(cbq_pkg::ACC_W'(1) <<< (cbq_pkg::SAMPLE_BITS - 1)) - cbq_pkg::ACC_W'(1);
	localparam logic signed [cbq_pkg::ACC_W-1:0] SMIN = -SMAX - cbq_pkg::ACC_W'(1);
	localparam logic [cbq_pkg::ACC_W-1:0] HALF =
		cbq_pkg::ACC_W'(1) << (cbq_pkg::COEF_FRAC - 1);

	logic signed [cbq_pkg::PROD_W-1:0] prod_s2;
	cbq_pkg::mac_ctl_t                 ctl_s2;
	logic signed [cbq_pkg::ACC_W-1:0]  acc_q;
	logic signed [cbq_pkg::ACC_W-1:0]  prod_ext;
	logic signed [cbq_pkg::ACC_W-1:0]  acc_base;
	logic signed [cbq_pkg::ACC_W-1:0]  rnd;
	logic signed [cbq_pkg::ACC_W-1:0]  sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= coef * operand;
	end

	assign prod_ext = cbq_pkg::ACC_W'(prod_s2);
	assign acc_base = ctl_s2.first ? '0 : acc_q;

	always_ff @(posedge clk) begin
		if (ctl_s2.vld) begin
			acc_q <= ctl_s2.sub ? (acc_base - prod_ext) : (acc_base + prod_ext);
		end
	end

	// round half up, floor shift, clip to sample range
	always_comb begin
		rnd  = acc_q + HALF;
		sh   = rnd >>> cbq_pkg::COEF_FRAC;
		clip = 1'b0;
		y    = sh[cbq_pkg::SAMPLE_BITS-1:0];
		if (sh > SMAX) begin
			y    = SMAX[cbq_pkg::SAMPLE_BITS-1:0];
			clip = 1'b1;
		end else if (sh < SMIN) begin
			y    = SMIN[cbq_pkg::SAMPLE_BITS-1:0];
			clip = 1'b1;
		end
	end

endmodule

@@ rtl/cbq_core.sv @@
// ----------------------------------------------------------------------------
// cbq_core
// Coefficient and history memories with the per-section sequencer.
// ----------------------------------------------------------------------------
module cbq_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  cbq_pkg::cfg_t                          cfg,
	input  logic                                   req_valid,
	output logic                                   req_stall,
	input  cbq_pkg::req_t                          req_data,
	output logic                                   res_valid,
	input  logic                                   res_ready,
	output cbq_pkg::rsp_t                          res_data
);

	cbq_pkg::state_t state_q, state_n;

	logic [cbq_pkg::SEC_CNT_W-1:0]         s_q;
	logic [cbq_pkg::K_W-1:0]               k_q;
	logic signed [cbq_pkg::SAMPLE_BITS-1:0] x_q;
	logic                                  clip_q;

	// coefficient memory, valid bits stand for the zero reset
	logic [cbq_pkg::COEF_BITS-1:0] coef_mem [cbq_pkg::CDEPTH];
	logic [cbq_pkg::CDEPTH-1:0]    coef_vld_q;
	logic [cbq_pkg::COEF_BITS-1:0] coef_rd_q;
	logic                          coef_rd_ok_q;
	logic                          coef_re;
	logic [cbq_pkg::CADDR_W-1:0]   coef_raddr;
	logic                          coef_we;
	logic [cbq_pkg::CADDR_W-1:0]   coef_waddr;

	// history memory, one row per section
	cbq_pkg::hist_row_t             hist_mem [cbq_pkg::SECTIONS];
	logic [cbq_pkg::SECTIONS-1:0]   hist_vld_q;
	cbq_pkg::hist_row_t             hist_rd_q;
	logic                           hist_rd_ok_q;
	cbq_pkg::hist_row_t             hist;
	cbq_pkg::hist_row_t             hist_wdata;
	logic                           hist_re;
	logic                           hist_we;
	logic                           hist_clr;
	logic [cbq_pkg::SEC_IDX_W-1:0]  row;
	logic [cbq_pkg::SEC_IDX_W-1:0]  clr_row;

	logic                    rd_vld_s1;
	logic [cbq_pkg::K_W-1:0] rd_k_s1;

	logic accept;
	logic is_filter;
	logic sec_done;
	logic sec_en;
	logic sec_ok;

	cbq_pkg::mac_ctl_t                      mac_ctl;
	logic signed [cbq_pkg::COEF_BITS-1:0]   mac_coef;
	logic signed [cbq_pkg::SAMPLE_BITS-1:0] mac_op;
	logic signed [cbq_pkg::SAMPLE_BITS-1:0] mac_y;
	logic                                   mac_clip;

	assign accept    = req_valid && !req_stall;
	assign is_filter = cbq_pkg::op_t'(req_data.opcode) == cbq_pkg::OP_FILTER;
	assign sec_done  = (32'(s_q) >= 32'(cfg.sections_in_use)) ||
	                   (32'(s_q) >= cbq_pkg::SECTIONS);
	assign sec_en    = |(cfg.section_enable & (cbq_pkg::CFG_EN_W'(1) << s_q));
	assign row       = cbq_pkg::SEC_IDX_W'(s_q);
	assign sec_ok    = 32'(req_data.section) < cbq_pkg::SECTIONS;
	assign clr_row   = cbq_pkg::SEC_IDX_W'(req_data.section);

	assign coef_we = accept && (cbq_pkg::op_t'(req_data.opcode) == cbq_pkg::OP_WRITE) &&
	                 sec_ok && (32'(req_data.coefficient_select) < cbq_pkg::NCOEF);
	assign coef_waddr = cbq_pkg::CADDR_W'(32'(req_data.section) * cbq_pkg::NCOEF +
	                                      32'(req_data.coefficient_select));
	assign hist_clr = accept && (cbq_pkg::op_t'(req_data.opcode) == cbq_pkg::OP_CLEAR) &&
	                  sec_ok;

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			cbq_pkg::ST_IDLE: begin
				if (accept && is_filter) state_n = cbq_pkg::ST_SEC;
			end
			cbq_pkg::ST_SEC: begin
				if (sec_done)    state_n = cbq_pkg::ST_DONE;
				else if (sec_en) state_n = cbq_pkg::ST_RUN;
			end
			cbq_pkg::ST_RUN: begin
				if (32'(k_q) == cbq_pkg::NCOEF + 1) state_n = cbq_pkg::ST_WB;
			end
			cbq_pkg::ST_WB: begin
				state_n = cbq_pkg::ST_SEC;
			end
			cbq_pkg::ST_DONE: begin
				if (res_ready) state_n = cbq_pkg::ST_IDLE;
			end
			default: state_n = cbq_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		req_stall  = 1'b1;
		res_valid  = 1'b0;
		coef_re    = 1'b0;
		coef_raddr = cbq_pkg::CADDR_W'(32'(s_q) * cbq_pkg::NCOEF + 32'(k_q));
		hist_re    = 1'b0;
		hist_we    = 1'b0;
		unique case (state_q)
			cbq_pkg::ST_IDLE: req_stall = 1'b0;
			cbq_pkg::ST_SEC: begin
				if (!sec_done && sec_en) begin
					coef_re    = 1'b1;
					coef_raddr = cbq_pkg::CADDR_W'(32'(s_q) * cbq_pkg::NCOEF);
					hist_re    = 1'b1;
				end
			end
			cbq_pkg::ST_RUN:  coef_re = 32'(k_q) < cbq_pkg::NCOEF;
			cbq_pkg::ST_WB:   hist_we = 1'b1;
			cbq_pkg::ST_DONE: res_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= cbq_pkg::ST_IDLE;
			s_q       <= '0;
			k_q       <= '0;
			clip_q    <= 1'b0;
			rd_vld_s1 <= 1'b0;
			rd_k_s1   <= '0;
		end else begin
			state_q   <= state_n;
			rd_vld_s1 <= coef_re;
			if (coef_re) rd_k_s1 <= (state_q == cbq_pkg::ST_SEC) ? '0 : k_q;
			unique case (state_q)
				cbq_pkg::ST_IDLE: begin
					s_q    <= '0;
					clip_q <= 1'b0;
				end
				cbq_pkg::ST_SEC: begin
					k_q <= cbq_pkg::K_W'(1);
					if (!sec_done && !sec_en) s_q <= s_q + 1'b1;
				end
				cbq_pkg::ST_RUN: k_q <= k_q + 1'b1;
				cbq_pkg::ST_WB: begin
					s_q    <= s_q + 1'b1;
					clip_q <= clip_q | mac_clip;
				end
				default: ;
			endcase
		end
	end

	// running sample: the input, then each enabled section's output
	always_ff @(posedge clk) begin
		if (state_q == cbq_pkg::ST_IDLE && accept) x_q <= req_data.sample_in;
		else if (state_q == cbq_pkg::ST_WB)         x_q <= mac_y;
	end

	// coefficient memory
	always_ff @(posedge clk) begin
		if (coef_we) coef_mem[coef_waddr] <= req_data.coefficient_value;
		if (coef_re) coef_rd_q <= coef_mem[coef_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_vld_q   <= '0;
			coef_rd_ok_q <= 1'b0;
		end else begin
			if (coef_we) coef_vld_q[coef_waddr] <= 1'b1;
			if (coef_re) coef_rd_ok_q <= coef_vld_q[coef_raddr];
		end
	end

	// history memory; a row is read at section start and written back at its end,
	// so reads and writes to one row never overlap
	assign hist = hist_rd_ok_q ? hist_rd_q : '0;

	always_comb begin
		hist_wdata.x1 = x_q;
		hist_wdata.x2 = hist.x1;
		hist_wdata.y1 = mac_y;
		hist_wdata.y2 = hist.y1;
	end

	always_ff @(posedge clk) begin
		if (hist_we) hist_mem[row] <= hist_wdata;
		if (hist_re) hist_rd_q <= hist_mem[row];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_vld_q   <= '0;
			hist_rd_ok_q <= 1'b0;
		end else begin
			if (hist_we)       hist_vld_q[row]     <= 1'b1;
			else if (hist_clr) hist_vld_q[clr_row] <= 1'b0;
			if (hist_re) hist_rd_ok_q <= hist_vld_q[row];
		end
	end

	// MAC operand select follows the coefficient on the read port
	always_comb begin
		mac_coef = coef_rd_ok_q ? coef_rd_q : '0;
		unique case (32'(rd_k_s1))
			cbq_pkg::C_B0: mac_op = x_q;
			cbq_pkg::C_B1: mac_op = hist.x1;
			cbq_pkg::C_B2: mac_op = hist.x2;
			cbq_pkg::C_A1: mac_op = hist.y1;
			cbq_pkg::C_A2: mac_op = hist.y2;
			default:       mac_op = '0;
		endcase
		mac_ctl.vld   = rd_vld_s1;
		mac_ctl.first = 32'(rd_k_s1) == cbq_pkg::C_B0;
		mac_ctl.sub   = 32'(rd_k_s1) >= cbq_pkg::C_A1;
	end

	cbq_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mac_ctl),
		.coef    (mac_coef),
		.operand (mac_op),
		.y       (mac_y),
		.clip    (mac_clip)
	);

	always_comb begin
		if (cfg.sections_in_use == '0) begin
			res_data.sample_out = '0;
			res_data.saturated  = 1'b0;
		end else begin
			res_data.sample_out = x_q;
			res_data.saturated  = clip_q;
		end
	end

endmodule

@@ rtl/cascaded_biquad_filter_bank.sv @@
// ----------------------------------------------------------------------------
// cascaded_biquad_filter_bank
// Cascade of up to eight direct-form-I biquads on Q1.23 samples.
// ----------------------------------------------------------------------------
// A request with opcode 0 runs its sample through sections 0 .. n-1 (n from
// sections_in_use, clamped to 8); an enabled section computes
// b0*x + b1*x1 + b2*x2 - a1*y1 - a2*y2 with Q8.24 coefficients, rounds half up,
// saturates to Q1.23 and flags clipping; a disabled section passes the sample.
// n = 0 returns 0. Opcode 1 writes one coefficient, opcode 2 zeroes one
// section's history, opcode 3 is ignored; none of these return anything.
// Write, clear and ignored requests leave the block idle. A filter request is
// run section by section on the single shared multiplier-accumulator, fed
// one coefficient per cycle from the coefficient RAM's read port; each enabled
// section passes the product and accumulator registers and ends with a
// writeback of its history row, while a disabled section is stepped over.
// A finished result sits in an output register, so the next request is taken
// while the previous result waits. Memories come out of reset reading zero;
// no clearing pass is needed. Write registers only while idle.
// Registers: 0x0 sections_in_use [3:0], 0x4 section_enable [7:0].
// ----------------------------------------------------------------------------
module cascaded_biquad_filter_bank (
	input  logic           clk,
	input  logic           arst_n,
	// configuration
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [2:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready,
	// requests
	input  logic           req_valid,
	output logic           req_stall,
	input  cbq_pkg::req_t  req_data,
	// results
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output cbq_pkg::rsp_t  rsp_data
);

	cbq_pkg::cfg_t cfg_q;
	logic          cfg_wr;

	logic          res_valid;
	logic          res_ready;
	cbq_pkg::rsp_t res_data;
	logic          rsp_valid_q;
	cbq_pkg::rsp_t rsp_data_q;

	// register file: word index is paddr[2], low bits ignored
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				cbq_pkg::REG_SECTIONS: cfg_q.sections_in_use <= pwdata[cbq_pkg::CFG_N_W-1:0];
				cbq_pkg::REG_ENABLE:   cfg_q.section_enable  <= pwdata[cbq_pkg::CFG_EN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			cbq_pkg::REG_SECTIONS: prdata = 32'(cfg_q.sections_in_use);
			cbq_pkg::REG_ENABLE:   prdata = 32'(cfg_q.section_enable);
			default:               prdata = '0;
		endcase
	end

	cbq_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

	// output register: refills in the cycle the old result is taken
	assign res_ready = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) rsp_data_q <= res_data;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_data_q;

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the cascaded biquad filter bank.
// ----------------------------------------------------------------------------
// Requests come from a queue that the main sequence fills and a clocked
// driver empties. Each accepted request is applied to a local copy of the
// coefficient RAM and the section taps. A filter request also pushes the
// expected output sample. A clocked monitor compares each accepted response
// against the oldest expectation. The run steps through several register
// settings and handshake idling profiles, and includes one long output
// hold-off.
// ----------------------------------------------------------------------------
module testbench;
	import cbq_pkg::*;

	localparam int     SETTLE_CYCLES  = 100;   // longer than the worst filter request
	localparam int     LONG_HOLD      = 300;
	localparam int     WATCHDOG_LIMIT = 20000;
	localparam int     PHASE_ITEMS    = 72;
	localparam longint SAMPLE_MAX     = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
	localparam longint SAMPLE_MIN     = -SAMPLE_MAX - 1;

	localparam logic [2:0] ADDR_SECTIONS = {REG_SECTIONS, 2'b00};
	localparam logic [2:0] ADDR_ENABLE   = {REG_ENABLE, 2'b00};

	// idling profiles: none, sender, receiver, both
	localparam int IDLE_SEND [4] = '{0, 53, 0, 38};
	localparam int IDLE_RECV [4] = '{0, 0, 53, 38};

	// register settings per random phase, extremes included
	localparam logic [3:0] PHASE_N  [8] = '{4'd8, 4'd15, 4'd0, 4'd3, 4'd8, 4'd1, 4'd4, 4'd2};
	localparam logic [7:0] PHASE_EN [8] = '{8'hFF, 8'hA5, 8'hFF, 8'h05, 8'h00, 8'h01,
		8'hF0, 8'h5A};

	logic        clk     = 1'b0;
	logic        arst_n  = 1'b0;
	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [2:0]  paddr   = '0;
	logic [31:0] pwdata  = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        req_valid = 1'b0;
	logic        req_stall;
	req_t        req_data  = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	rsp_t        rsp_data;

	cascaded_biquad_filter_bank DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

	// ---------------------------------------------------------------- shared state
	req_t pending_reqs[$];        // requests waiting for the driver
	rsp_t expected_samples[$];    // predicted filter outputs, oldest first
	int   errors          = 0;
	int   send_idle_pct   = 0;
	int   recv_stall_pct  = 0;
	int   holds_asked     = 0;    // bumped by the sequence, served by the receiver

	// local copy of the block's state
	logic signed [COEF_BITS-1:0]   coef_ram [SECTIONS][NCOEF];
	logic signed [SAMPLE_BITS-1:0] x_taps   [SECTIONS][2];
	logic signed [SAMPLE_BITS-1:0] y_taps   [SECTIONS][2];
	logic [CFG_N_W-1:0]            cfg_sections = '0;
	logic [CFG_EN_W-1:0]           cfg_enable   = '0;

	initial begin
		for (int s = 0; s < SECTIONS; s++) begin
			for (int c = 0; c < NCOEF; c++)
				coef_ram[s][c] = '0;
			x_taps[s] = '{default: '0};
			y_taps[s] = '{default: '0};
		end
	end

	// ---------------------------------------------------------------- clock, reset
	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	// ---------------------------------------------------------------- predictor
	// Runs one sample through the cascade, updating the local taps.
	// Products are Q9.47 summed in 64 bits; round half up, floor by COEF_FRAC,
	// clip to Q1.23. The clipped value is what goes into the output taps.
	function automatic rsp_t cascade_predict(input logic signed [SAMPLE_BITS-1:0] x_in);
		rsp_t   res;
		longint acc;
		longint v;
		int     n;
		res = '0;
		n   = (int'(cfg_sections) > SECTIONS) ? SECTIONS : int'(cfg_sections);
		if (n == 0)
			return res;   // nothing traversed: zero out, taps untouched
		v = longint'(x_in);
		for (int s = 0; s < n; s++) begin
			// sections without an enable bit simply pass the sample
			if (s < CFG_EN_W && cfg_enable[s]) begin
				acc = longint'(coef_ram[s][C_B0]) * v
					+ longint'(coef_ram[s][C_B1]) * longint'(x_taps[s][0])
					+ longint'(coef_ram[s][C_B2]) * longint'(x_taps[s][1])
					- longint'(coef_ram[s][C_A1]) * longint'(y_taps[s][0])
					- longint'(coef_ram[s][C_A2]) * longint'(y_taps[s][1]);
				acc = acc + (64'sd1 <<< (COEF_FRAC - 1));
				acc = acc >>> COEF_FRAC;
				if (acc > SAMPLE_MAX) begin
					acc           = SAMPLE_MAX;
					res.saturated = 1'b1;
				end else if (acc < SAMPLE_MIN) begin
					acc           = SAMPLE_MIN;
					res.saturated = 1'b1;
				end
				x_taps[s][1] = x_taps[s][0];
				x_taps[s][0] = v[SAMPLE_BITS-1:0];
				y_taps[s][1] = y_taps[s][0];
				y_taps[s][0] = acc[SAMPLE_BITS-1:0];
				v            = acc;
			end
		end
		res.sample_out = v[SAMPLE_BITS-1:0];
		return res;
	endfunction

	// Applies one accepted request to the local state.
	function automatic void track_request(input req_t r);
		case (op_t'(r.opcode))
			OP_FILTER: expected_samples.push_back(cascade_predict(r.sample_in));
			OP_WRITE: begin
				// bad select leaves the RAM alone
				if (int'(r.section) < SECTIONS && int'(r.coefficient_select) < NCOEF)
					coef_ram[r.section][r.coefficient_select] = r.coefficient_value;
			end
			OP_CLEAR: begin
				// taps only, coefficients stay
				if (int'(r.section) < SECTIONS) begin
					x_taps[r.section] = '{default: '0};
					y_taps[r.section] = '{default: '0};
				end
			end
			default: ;   // OP_NOP: ignored
		endcase
	endfunction

	// ---------------------------------------------------------------- driver
	// Holds a request until taken; after each acceptance it either offers the
	// next one or idles, by the current profile. Stall is sampled pre-edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req_data  <= '0;
		end else begin
			if (req_valid && !req_stall)
				track_request(req_data);
			if (!req_valid || !req_stall) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req_valid <= 1'b1;
					req_data  <= pending_reqs.pop_front();
				end else
					req_valid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- receiver
	int hold_left  = 0;
	int holds_done = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall  <= 1'b0;
			hold_left  <= 0;
			holds_done <= 0;
		end else if (holds_done != holds_asked) begin
			// long hold-off: lets the output register fill and back up the input
			holds_done <= holds_done + 1;
			hold_left  <= LONG_HOLD;
			rsp_stall  <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else
			rsp_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// ---------------------------------------------------------------- monitor
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_samples.size() == 0) begin
				$error("sample_out: expected no response, got %0d", rsp_data.sample_out);
				errors++;
			end else begin
				want = expected_samples.pop_front();
				if (rsp_data.sample_out !== want.sample_out) begin
					$error("sample_out: expected %0d, got %0d", want.sample_out,
						rsp_data.sample_out);
					errors++;
				end
				if (rsp_data.saturated !== want.saturated) begin
					$error("saturated: expected %0b, got %0b", want.saturated,
						rsp_data.saturated);
					errors++;
				end
			end
		end
	end

	// ---------------------------------------------------------------- watchdog
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)
				|| (psel && penable && pready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// ---------------------------------------------------------------- APB access
	task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic reg_check(input logic [2:0] addr, input logic [31:0] want, input string name);
		logic [31:0] got;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		got = prdata;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	// Only called with the block idle; mirror is updated off-edge.
	task automatic set_config(input logic [3:0] n, input logic [7:0] en);
		reg_write(ADDR_SECTIONS, {28'd0, n});
		reg_write(ADDR_ENABLE, {24'd0, en});
		reg_check(ADDR_SECTIONS, {28'd0, n}, "sections_in_use");
		reg_check(ADDR_ENABLE, {24'd0, en}, "section_enable");
		@(negedge clk);
		cfg_sections = n;
		cfg_enable   = en;
	endtask

	// ---------------------------------------------------------------- request builders
	// Unused fields get random content so every bit toggles.
	function automatic req_t filter_req(input logic [SAMPLE_BITS-1:0] s);
		req_t r;
		r           = req_t'({$urandom, $urandom});
		r.opcode    = OP_FILTER;
		r.sample_in = s;
		return r;
	endfunction

	function automatic req_t coef_req(input int sec, input int sel, input logic [31:0] v);
		req_t r;
		r                    = req_t'({$urandom, $urandom});
		r.opcode             = OP_WRITE;
		r.section            = 3'(sec);
		r.coefficient_select = 3'(sel);
		r.coefficient_value  = v;
		return r;
	endfunction

	function automatic req_t clear_req(input int sec);
		req_t r;
		r         = req_t'({$urandom, $urandom});
		r.opcode  = OP_CLEAR;
		r.section = 3'(sec);
		return r;
	endfunction

	// mostly within +/-2.0 so filters stay in range; sometimes anything
	function automatic logic [31:0] rand_coef();
		if ($urandom_range(99) < 70)
			return 32'($urandom_range(32'h03FF_FFFF)) - 32'h0200_0000;
		return $urandom;
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] rand_sample();
		int pick;
		pick = $urandom_range(99);
		if (pick < 5)
			return SAMPLE_BITS'(SAMPLE_MAX);
		if (pick < 10)
			return SAMPLE_BITS'(SAMPLE_MIN);
		return SAMPLE_BITS'($urandom);
	endfunction

	task automatic load_section(input int sec);
		for (int c = 0; c < NCOEF; c++)
			pending_reqs.push_back(coef_req(sec, c, rand_coef()));
	endtask

	task automatic push_random(input int count);
		int pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < 60)
				pending_reqs.push_back(filter_req(rand_sample()));
			else if (pick < 82)
				pending_reqs.push_back(coef_req($urandom_range(SECTIONS - 1),
					$urandom_range(7), rand_coef()));
			else if (pick < 94)
				pending_reqs.push_back(clear_req($urandom_range(SECTIONS - 1)));
			else begin
				pending_reqs.push_back(req_t'({$urandom, $urandom}));
				pending_reqs[$].opcode = OP_NOP;
			end
		end
	endtask

	// sender pause: everything out, every response back, then settle
	task automatic wait_idle();
		do @(negedge clk);
		while (pending_reqs.size() != 0 || req_valid || expected_samples.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// ---------------------------------------------------------------- sequence
	initial begin
		req_t nop;
		int   mode;
		wait (arst_n === 1'b1);
		@(negedge clk);

		// --- directed: one section, unity gain, then extremes and every op
		set_config(4'd1, 8'h01);
		pending_reqs.push_back(coef_req(0, C_B0, 32'h0100_0000));
		pending_reqs.push_back(filter_req(SAMPLE_BITS'(SAMPLE_MAX)));
		pending_reqs.push_back(filter_req(SAMPLE_BITS'(SAMPLE_MIN)));
		pending_reqs.push_back(filter_req('0));
		pending_reqs.push_back(coef_req(0, C_B0, 32'h0200_0000));     // gain 2: clips
		pending_reqs.push_back(filter_req(SAMPLE_BITS'(SAMPLE_MAX)));
		pending_reqs.push_back(filter_req(SAMPLE_BITS'(SAMPLE_MIN)));
		pending_reqs.push_back(coef_req(0, C_B0, 32'h7FFF_FFFF));     // largest coefficient
		pending_reqs.push_back(filter_req(24'h000001));
		pending_reqs.push_back(coef_req(0, C_B0, 32'h8000_0000));     // most negative
		pending_reqs.push_back(filter_req(SAMPLE_BITS'(SAMPLE_MIN)));
		pending_reqs.push_back(coef_req(0, C_B1, 32'h0080_0000));
		pending_reqs.push_back(coef_req(0, C_B2, 32'hFF80_0000));
		pending_reqs.push_back(coef_req(0, C_A1, 32'h0040_0000));
		pending_reqs.push_back(coef_req(0, C_A2, 32'hFFC0_0000));
		pending_reqs.push_back(coef_req(0, NCOEF, 32'h1234_5678));    // bad select
		pending_reqs.push_back(coef_req(0, NCOEF + 2, 32'h7654_3210)); // bad select
		pending_reqs.push_back(filter_req(24'h123456));
		pending_reqs.push_back(filter_req(24'hFEDCBA));
		pending_reqs.push_back(clear_req(0));                          // taps only
		pending_reqs.push_back(filter_req(24'h400000));
		nop        = req_t'({$urandom, $urandom});
		nop.opcode = OP_NOP;
		pending_reqs.push_back(nop);
		pending_reqs.push_back(coef_req(SECTIONS - 1, C_A2, 32'h00C0_0000));
		pending_reqs.push_back(clear_req(SECTIONS - 1));
		pending_reqs.push_back(filter_req(24'hFFFFFF));
		wait_idle();

		// --- back-pressure: full cascade, receiver holds off while requests pile up
		set_config(4'd8, 8'hFF);
		for (int s = 0; s < SECTIONS; s++)
			load_section(s);
		holds_asked = holds_asked + 1;
		for (int i = 0; i < 40; i++)
			pending_reqs.push_back(filter_req(rand_sample()));
		wait_idle();

		// --- random phases over the register settings and idling profiles
		for (int p = 0; p < 8; p++) begin
			mode           = p % 4;
			send_idle_pct  = IDLE_SEND[mode];
			recv_stall_pct = IDLE_RECV[mode];
			if (p == 7)
				set_config(4'($urandom_range(15)), 8'($urandom));
			else
				set_config(PHASE_N[p], PHASE_EN[p]);
			// a couple of full coefficient loads, then the mix
			load_section($urandom_range(SECTIONS - 1));
			load_section($urandom_range(SECTIONS - 1));
			push_random(PHASE_ITEMS);
			wait_idle();
		end

		if (expected_samples.size() != 0) begin
			$error("sample_out: %0d responses never arrived", expected_samples.size());
			errors++;
		end
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ files.f @@
rtl/cbq_pkg.sv
rtl/cbq_mac.sv
rtl/cbq_core.sv
rtl/cascaded_biquad_filter_bank.sv
verif/testbench.sv
